[rtl/ssi_pkg.sv]
package ssi_pkg;

  // Coordinate and intermediate widths, all exact for Q12.4 inputs.
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W;
  localparam int SUM_W   = MAG_W + 1;
  localparam int REM_W   = SUM_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic [REM_W-1:0]          rem_t;

  // One input transaction: the end points of both segments.
  typedef struct packed {
    coord_t a_begin_x;
    coord_t a_begin_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_begin_x;
    coord_t b_begin_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic   hit;
    logic   point_valid;
    coord_t point_x;
    coord_t point_y;
  } out_res_t;

  // Control flags that travel down the pipeline with each transaction.
  typedef struct packed {
    logic valid;
    logic hit;
    logic point_valid;
    logic at_end;
  } ctl_t;

  // Segment A data needed at the interpolation stage.
  typedef struct packed {
    coord_t pa_x;
    coord_t pa_y;
    coord_t qa_x;
    coord_t qa_y;
    diff_t  da_x;
    diff_t  da_y;
  } side_t;

endpackage

[rtl/ssi_front.sv]
module ssi_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  ssi_pkg::in_item_t item,
  output ssi_pkg::ctl_t    ctl,
  output ssi_pkg::side_t   side,
  output ssi_pkg::mag_t    r1,
  output ssi_pkg::sum_t    sum
);
  import ssi_pkg::*;

  // True when the product of the two values is zero or negative.
  function automatic logic nonpos(input cross_t a, input cross_t b);
    return (a == '0) || (b == '0) || (a[CROSS_W-1] != b[CROSS_W-1]);
  endfunction

  function automatic mag_t magnitude(input cross_t c);
    cross_t n;
    n = -c;
    return c[CROSS_W-1] ? mag_t'(n) : mag_t'(c);
  endfunction

  // Stage 1: direction vectors and offsets between end points.
  diff_t pax, pay, qax, qay, pbx, pby, qbx, qby;
  logic  v1_r;
  diff_t dax_r, day_r, dbx_r, dby_r;
  diff_t e1x_r, e1y_r, e2x_r, e2y_r, e3x_r, e3y_r, e4x_r, e4y_r;
  side_t side1_nxt, side1_r;

  assign pax = DIFF_W'(item.a_begin_x);
  assign pay = DIFF_W'(item.a_begin_y);
  assign qax = DIFF_W'(item.a_end_x);
  assign qay = DIFF_W'(item.a_end_y);
  assign pbx = DIFF_W'(item.b_begin_x);
  assign pby = DIFF_W'(item.b_begin_y);
  assign qbx = DIFF_W'(item.b_end_x);
  assign qby = DIFF_W'(item.b_end_y);

  always_comb begin
    side1_nxt.pa_x = item.a_begin_x;
    side1_nxt.pa_y = item.a_begin_y;
    side1_nxt.qa_x = item.a_end_x;
    side1_nxt.qa_y = item.a_end_y;
    side1_nxt.da_x = qax - pax;
    side1_nxt.da_y = qay - pay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    dax_r   <= qax - pax;
    day_r   <= qay - pay;
    dbx_r   <= qbx - pbx;
    dby_r   <= qby - pby;
    e1x_r   <= pbx - pax;
    e1y_r   <= pby - pay;
    e2x_r   <= qbx - pax;
    e2y_r   <= qby - pay;
    e3x_r   <= pax - pbx;
    e3y_r   <= pay - pby;
    e4x_r   <= qax - pbx;
    e4y_r   <= qay - pby;
    side1_r <= side1_nxt;
  end

  // Stage 2: the eight partial products of the cross products.
  logic  v2_r;
  prod_t p1a_r, p1b_r, p2a_r, p2b_r, p3a_r, p3b_r, p4a_r, p4b_r;
  side_t side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p1a_r   <= PROD_W'(dax_r) * PROD_W'(e1y_r);
    p1b_r   <= PROD_W'(day_r) * PROD_W'(e1x_r);
    p2a_r   <= PROD_W'(dax_r) * PROD_W'(e2y_r);
    p2b_r   <= PROD_W'(day_r) * PROD_W'(e2x_r);
    p3a_r   <= PROD_W'(dbx_r) * PROD_W'(e3y_r);
    p3b_r   <= PROD_W'(dby_r) * PROD_W'(e3x_r);
    p4a_r   <= PROD_W'(dbx_r) * PROD_W'(e4y_r);
    p4b_r   <= PROD_W'(dby_r) * PROD_W'(e4x_r);
    side2_r <= side1_r;
  end

  // Stage 3: the four cross products.
  logic   v3_r;
  cross_t c1_r, c2_r, c3_r, c4_r;
  side_t  side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_r    <= CROSS_W'(p1a_r) - CROSS_W'(p1b_r);
    c2_r    <= CROSS_W'(p2a_r) - CROSS_W'(p2b_r);
    c3_r    <= CROSS_W'(p3a_r) - CROSS_W'(p3b_r);
    c4_r    <= CROSS_W'(p4a_r) - CROSS_W'(p4b_r);
    side3_r <= side2_r;
  end

  // Stage 4: hit test from the signs, special cases and magnitudes.
  ctl_t  ctl4_nxt, ctl4_r;
  mag_t  r1_4_r, r2_4_r;
  side_t side4_r;

  always_comb begin
    ctl4_nxt.valid       = v3_r;
    ctl4_nxt.hit         = nonpos(c1_r, c2_r) && nonpos(c3_r, c4_r);
    ctl4_nxt.point_valid = ctl4_nxt.hit && ((c3_r != '0) || (c4_r != '0));
    ctl4_nxt.at_end      = ctl4_nxt.point_valid && (c4_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r.valid <= 1'b0;
    end else begin
      ctl4_r <= ctl4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r1_4_r  <= magnitude(c3_r);
    r2_4_r  <= magnitude(c4_r);
    side4_r <= side3_r;
  end

  // Stage 5: ratio denominator.
  ctl_t  ctl5_r;
  mag_t  r1_5_r;
  sum_t  sum5_r;
  side_t side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r.valid <= 1'b0;
    end else begin
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    r1_5_r  <= r1_4_r;
    sum5_r  <= SUM_W'(r1_4_r) + SUM_W'(r2_4_r);
    side5_r <= side4_r;
  end

  assign ctl  = ctl5_r;
  assign side = side5_r;
  assign r1   = r1_5_r;
  assign sum  = sum5_r;

endmodule

[rtl/ssi_div.sv]
module ssi_div #(
  parameter int RATIO_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssi_pkg::ctl_t         ctl_i,
  input  ssi_pkg::side_t        side_i,
  input  ssi_pkg::mag_t         r1_i,
  input  ssi_pkg::sum_t         sum_i,
  output ssi_pkg::ctl_t         ctl_o,
  output ssi_pkg::side_t        side_o,
  output logic [RATIO_BITS-1:0] q_o
);
  import ssi_pkg::*;

  // Restoring division, one quotient bit per pipeline stage.
  ctl_t                  ctl_r  [RATIO_BITS];
  side_t                 side_r [RATIO_BITS];
  rem_t                  rem_r  [RATIO_BITS];
  sum_t                  sum_r  [RATIO_BITS];
  logic [RATIO_BITS-1:0] q_r    [RATIO_BITS];

  for (genvar i = 0; i < RATIO_BITS; i++) begin : g_step
    ctl_t                  ctl_in;
    side_t                 side_in;
    rem_t                  rem_in;
    sum_t                  sum_in;
    logic [RATIO_BITS-1:0] q_in;
    rem_t                  rem_sh;
    logic                  take;

    if (i == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign side_in = side_i;
      assign rem_in  = REM_W'(r1_i);
      assign sum_in  = sum_i;
      assign q_in    = '0;
    end else begin : g_rest
      assign ctl_in  = ctl_r[i-1];
      assign side_in = side_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign sum_in  = sum_r[i-1];
      assign q_in    = q_r[i-1];
    end

    // Shift the partial remainder and subtract the divisor when it fits.
    assign rem_sh = {rem_in[REM_W-2:0], 1'b0};
    assign take   = (rem_sh >= REM_W'(sum_in));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i].valid <= 1'b0;
      end else begin
        ctl_r[i] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[i] <= side_in;
      sum_r[i]  <= sum_in;
      rem_r[i]  <= take ? (rem_sh - REM_W'(sum_in)) : rem_sh;
      q_r[i]    <= {q_in[RATIO_BITS-2:0], take};
    end
  end

  assign ctl_o  = ctl_r[RATIO_BITS-1];
  assign side_o = side_r[RATIO_BITS-1];
  assign q_o    = q_r[RATIO_BITS-1];

endmodule

[rtl/ssi_interp.sv]
module ssi_interp #(
  parameter int RATIO_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssi_pkg::ctl_t         ctl_i,
  input  ssi_pkg::side_t        side_i,
  input  logic [RATIO_BITS-1:0] q_i,
  output logic                  out_strobe,
  output ssi_pkg::out_res_t     out_res
);
  import ssi_pkg::*;

  localparam int MUL_W = DIFF_W + RATIO_BITS + 1;

  // Multiply stage: direction of segment A times the unsigned ratio.
  ctl_t                    ctl_m_r;
  side_t                   side_m_r;
  logic signed [MUL_W-1:0] prod_x_r, prod_y_r;
  logic signed [MUL_W-1:0] q_ext;

  assign q_ext = MUL_W'($signed({1'b0, q_i}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_m_r.valid <= 1'b0;
    end else begin
      ctl_m_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    side_m_r <= side_i;
    prod_x_r <= MUL_W'(side_i.da_x) * q_ext;
    prod_y_r <= MUL_W'(side_i.da_y) * q_ext;
  end

  // Output stage: dropping the fraction bits rounds toward minus infinity.
  out_res_t res_nxt, res_r;
  logic     strobe_r;

  always_comb begin
    res_nxt.hit         = ctl_m_r.hit;
    res_nxt.point_valid = ctl_m_r.point_valid;
    if (!ctl_m_r.point_valid) begin
      res_nxt.point_x = side_m_r.pa_x;
      res_nxt.point_y = side_m_r.pa_y;
    end else if (ctl_m_r.at_end) begin
      res_nxt.point_x = side_m_r.qa_x;
      res_nxt.point_y = side_m_r.qa_y;
    end else begin
      res_nxt.point_x = side_m_r.pa_x + prod_x_r[RATIO_BITS +: COORD_W];
      res_nxt.point_y = side_m_r.pa_y + prod_y_r[RATIO_BITS +: COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_m_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule

[rtl/segment_segment_intersection_top.sv]
// Channel   Handshake                       Payload
// input     start high while busy low       in_item (in_item_t)
// result    out_strobe high for one cycle   out_res (out_res_t)
//
// A new transaction can be taken in every cycle; busy is high only during
// reset and the cycle after it.
// Each result passes through the five front stages, one restoring-division
// stage per ratio bit and the multiply and output stages.
// Reset is synchronous and clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never holds.
module segment_segment_intersection_top #(
  parameter int RATIO_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ssi_pkg::in_item_t in_item,
  output logic              out_strobe,
  output ssi_pkg::out_res_t out_res
);
  import ssi_pkg::*;

  localparam int LATENCY = RATIO_BITS + 7;

  // Busy only while coming out of reset.
  logic busy_r;
  logic in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy    = busy_r;
  assign in_take = start && !busy_r;

  // Cross products, hit test and ratio terms.
  ctl_t                  f_ctl, d_ctl;
  side_t                 f_side, d_side;
  mag_t                  f_r1;
  sum_t                  f_sum;
  logic [RATIO_BITS-1:0] d_q;

  ssi_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_vld(in_take),
    .item  (in_item),
    .ctl   (f_ctl),
    .side  (f_side),
    .r1    (f_r1),
    .sum   (f_sum)
  );

  // Ratio r1 / (r1 + r2).
  ssi_div #(
    .RATIO_BITS(RATIO_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (f_ctl),
    .side_i(f_side),
    .r1_i  (f_r1),
    .sum_i (f_sum),
    .ctl_o (d_ctl),
    .side_o(d_side),
    .q_o   (d_q)
  );

  // Intersection point.
  ssi_interp #(
    .RATIO_BITS(RATIO_BITS)
  ) u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (d_ctl),
    .side_i    (d_side),
    .q_i       (d_q),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

`ifndef SYNTHESIS
  // Every accepted transaction produces its result after the fixed latency.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> ##LATENCY out_strobe)
    else $error("result missing after accepted transaction");

  // No result appears without a transaction accepted the latency earlier.
  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_take, LATENCY))
    else $error("result without matching transaction");

  // A valid point is only reported for a hit.
  a_valid_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.point_valid) |-> out_res.hit)
    else $error("point_valid without hit");

  // Reset empties the output stage.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ssi_pkg::*;

  localparam int RATIO_BITS = 16;
  localparam int LATENCY    = RATIO_BITS + 7;
  localparam int COORD_MAX  = 32767;
  localparam int COORD_MIN  = -32768;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_item_t in_item;
  logic     out_strobe;
  out_res_t out_res;

  // Expected results in transaction order, plus run statistics.
  out_res_t pending_points[$];
  out_res_t want;
  int       n_sent      = 0;
  int       n_checked   = 0;
  int       n_points    = 0;
  int       n_collinear = 0;
  int       n_misses    = 0;
  int       n_errors    = 0;

  segment_segment_intersection_top #(
    .RATIO_BITS(RATIO_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Computes the expected result of one segment pair. All products fit in
  // 64 bits for 16-bit coordinates, so the arithmetic here is exact.
  function automatic out_res_t predict_crossing(input in_item_t pair);
    longint   pax, pay, qax, qay, pbx, pby, qbx, qby;
    longint   dax, day, dbx, dby;
    longint   c1, c2, c3, c4;
    longint   r1, r2, tot, q;
    bit       a_straddles, b_straddles;
    out_res_t res;
    pax = pair.a_begin_x;
    pay = pair.a_begin_y;
    qax = pair.a_end_x;
    qay = pair.a_end_y;
    pbx = pair.b_begin_x;
    pby = pair.b_begin_y;
    qbx = pair.b_end_x;
    qby = pair.b_end_y;
    dax = qax - pax;
    day = qay - pay;
    dbx = qbx - pbx;
    dby = qby - pby;
    c1  = dax * (pby - pay) - day * (pbx - pax);
    c2  = dax * (qby - pay) - day * (qbx - pax);
    c3  = dbx * (pay - pby) - dby * (pax - pbx);
    c4  = dbx * (qay - pby) - dby * (qax - pbx);

    res.hit         = 1'b0;
    res.point_valid = 1'b0;
    res.point_x     = pair.a_begin_x;
    res.point_y     = pair.a_begin_y;

    // Each segment's end points must lie on opposite sides of, or on, the
    // other segment's line.
    a_straddles = (c1 == 0) || (c2 == 0) || ((c1 < 0) != (c2 < 0));
    b_straddles = (c3 == 0) || (c4 == 0) || ((c3 < 0) != (c4 < 0));
    if (a_straddles && b_straddles) begin
      res.hit = 1'b1;
      r1  = (c3 < 0) ? -c3 : c3;
      r2  = (c4 < 0) ? -c4 : c4;
      tot = r1 + r2;
      // A collinear pair has no single point: the begin point stays.
      if (tot != 0) begin
        res.point_valid = 1'b1;
        if (r2 == 0) begin
          res.point_x = pair.a_end_x;
          res.point_y = pair.a_end_y;
        end else begin
          q = (r1 <<< RATIO_BITS) / tot;
          res.point_x = coord_t'(pax + ((dax * q) >>> RATIO_BITS));
          res.point_y = coord_t'(pay + ((day * q) >>> RATIO_BITS));
        end
      end
    end
    return res;
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  // Uniform value in [-span, span].
  function automatic longint rand_in(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic in_item_t make_pair(input int ax, input int ay, input int aex,
                                         input int aey, input int bx, input int by,
                                         input int bex, input int bey);
    in_item_t pair;
    pair.a_begin_x = coord_t'(ax);
    pair.a_begin_y = coord_t'(ay);
    pair.a_end_x   = coord_t'(aex);
    pair.a_end_y   = coord_t'(aey);
    pair.b_begin_x = coord_t'(bx);
    pair.b_begin_y = coord_t'(by);
    pair.b_end_x   = coord_t'(bex);
    pair.b_end_y   = coord_t'(bey);
    return pair;
  endfunction

  // Builds a pair that crosses by construction: B passes through a point on
  // A. A zero scale puts one of B's end points on that point.
  function automatic in_item_t make_crossing();
    int       span, t, s;
    longint   ax, ay, aex, aey, px, py, vx, vy;
    in_item_t pair;
    span = ($urandom_range(0, 3) == 0) ? COORD_MAX : 1024;
    ax   = rand_in(span);
    ay   = rand_in(span);
    aex  = rand_in(span);
    aey  = rand_in(span);
    t    = $urandom_range(0, 256);
    px   = ax + ((aex - ax) * t) / 256;
    py   = ay + ((aey - ay) * t) / 256;
    vx   = rand_in(span / 2);
    vy   = rand_in(span / 2);
    s    = $urandom_range(0, 8);
    pair.a_begin_x = coord_t'(ax);
    pair.a_begin_y = coord_t'(ay);
    pair.a_end_x   = coord_t'(aex);
    pair.a_end_y   = coord_t'(aey);
    pair.b_begin_x = clamp_coord(px + vx);
    pair.b_begin_y = clamp_coord(py + vy);
    pair.b_end_x   = clamp_coord(px - (vx * s) / 4);
    pair.b_end_y   = clamp_coord(py - (vy * s) / 4);
    if ($urandom_range(0, 1) == 1) begin
      pair = make_pair(int'(pair.a_begin_x), int'(pair.a_begin_y),
                       int'(pair.a_end_x), int'(pair.a_end_y),
                       int'(pair.b_end_x), int'(pair.b_end_y),
                       int'(pair.b_begin_x), int'(pair.b_begin_y));
    end
    return pair;
  endfunction

  // All four points on one line through a random base.
  function automatic in_item_t make_collinear();
    longint bx, by, sx, sy;
    int     k[4];
    bx = rand_in(16000);
    by = rand_in(16000);
    sx = rand_in(64);
    sy = rand_in(64);
    foreach (k[i]) k[i] = int'(rand_in(100));
    return make_pair(int'(clamp_coord(bx + sx * k[0])), int'(clamp_coord(by + sy * k[0])),
                     int'(clamp_coord(bx + sx * k[1])), int'(clamp_coord(by + sy * k[1])),
                     int'(clamp_coord(bx + sx * k[2])), int'(clamp_coord(by + sy * k[2])),
                     int'(clamp_coord(bx + sx * k[3])), int'(clamp_coord(by + sy * k[3])));
  endfunction

  // Mostly no idle cycles, some short gaps and a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Offers one transaction at the falling edge, waits for it to be taken and
  // records its expected result. Start stays high when no gap follows.
  task automatic send_pair(input in_item_t pair, input int unsigned gap);
    in_item <= pair;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_points.push_back(predict_crossing(pair));
    n_sent++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  // Compares every result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_points.size() == 0) begin
        $error("result with no transaction outstanding: hit=%0b point=(%0d, %0d)",
               out_res.hit, out_res.point_x, out_res.point_y);
        n_errors++;
      end else begin
        want = pending_points.pop_front();
        n_checked++;
        if (!want.hit) n_misses++;
        else if (!want.point_valid) n_collinear++;
        else n_points++;
        if (out_res.hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, out_res.hit);
          n_errors++;
        end
        if (out_res.point_valid !== want.point_valid) begin
          $error("point_valid: expected %0b, got %0b", want.point_valid,
                 out_res.point_valid);
          n_errors++;
        end
        if (out_res.point_x !== want.point_x) begin
          $error("point_x: expected %0d, got %0d", want.point_x, out_res.point_x);
          n_errors++;
        end
        if (out_res.point_y !== want.point_y) begin
          $error("point_y: expected %0d, got %0d", want.point_y, out_res.point_y);
          n_errors++;
        end
      end
    end
  end

  // Hand-picked pairs: coordinate extremes, touching ends, collinear and
  // degenerate segments, misses and rounding of negative offsets.
  task automatic test_corner_cases();
    in_item_t pairs[$];
    pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pairs.push_back(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    pairs.push_back(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    pairs.push_back(make_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                              COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    pairs.push_back(make_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                              COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
    pairs.push_back(make_pair(COORD_MIN, 0, COORD_MAX, 0, 0, COORD_MIN, 0, COORD_MAX));
    pairs.push_back(make_pair(-160, 0, 160, 0, 0, -160, 0, 160));
    // Parallel and apart.
    pairs.push_back(make_pair(0, 0, 320, 0, 0, 16, 320, 16));
    // Collinear, overlapping and apart.
    pairs.push_back(make_pair(0, 0, 320, 0, 160, 0, 480, 0));
    pairs.push_back(make_pair(0, 0, 16, 0, 320, 0, 480, 0));
    // A ends on B, so the point is A's end; A begins on B, so ratio zero.
    pairs.push_back(make_pair(0, 0, 160, 160, 0, 320, 320, 0));
    pairs.push_back(make_pair(160, 160, 320, 320, 0, 320, 320, 0));
    // B touches the inside of A, and just misses it.
    pairs.push_back(make_pair(-320, 0, 320, 0, 0, 0, 0, 320));
    pairs.push_back(make_pair(-320, 0, 320, 0, 0, 16, 0, 320));
    // Lines cross but the segments stop short.
    pairs.push_back(make_pair(0, 0, 16, 16, 320, 0, 0, 320));
    // Negative offsets that round toward minus infinity.
    pairs.push_back(make_pair(-1, -1, -33, -7, -20, 10, -10, -20));
    pairs.push_back(make_pair(0, 0, 1, 3, 0, 3, 1, 0));
    // Zero-length A on B and beside it.
    pairs.push_back(make_pair(160, 0, 160, 0, 0, 0, 320, 0));
    pairs.push_back(make_pair(160, 16, 160, 16, 0, 0, 320, 0));
    // Alternating bit patterns.
    pairs.push_back(make_pair(21845, -21846, -21846, 21845,
                              -21846, -21846, 21845, 21845));
    foreach (pairs[i]) send_pair(pairs[i], (i < 10) ? 0 : pick_gap());
  endtask

  // The sender holds off until the pipeline has emptied, then resumes.
  task automatic test_drain_pause();
    repeat (5) send_pair(make_crossing(), 0);
    wait_drained();
    repeat (5) send_pair(make_crossing(), pick_gap());
    wait_drained();
  endtask

  // One pair per cycle with no idle cycles at all.
  task automatic test_back_to_back();
    repeat (100) send_pair(make_crossing(), 0);
  endtask

  // Mostly crossing pairs, with free random, collinear, small-box, touching
  // and zero-length pairs mixed in.
  task automatic test_random_mix();
    int unsigned sel;
    in_item_t    pair;
    longint      px, py;
    repeat (420) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        pair = make_crossing();
      end else if (sel < 65) begin
        pair = in_item_t'({$urandom, $urandom, $urandom, $urandom});
      end else if (sel < 75) begin
        pair = make_collinear();
      end else if (sel < 85) begin
        pair = make_pair(int'(rand_in(64)), int'(rand_in(64)),
                         int'(rand_in(64)), int'(rand_in(64)),
                         int'(rand_in(64)), int'(rand_in(64)),
                         int'(rand_in(64)), int'(rand_in(64)));
      end else if (sel < 93) begin
        // B ends on one of A's end points.
        pair = make_crossing();
        pair.b_end_x = ($urandom_range(0, 1) == 1) ? pair.a_end_x : pair.a_begin_x;
        pair.b_end_y = (pair.b_end_x == pair.a_end_x) ? pair.a_end_y : pair.a_begin_y;
      end else begin
        px   = rand_in(COORD_MAX);
        py   = rand_in(COORD_MAX);
        pair = make_pair(int'(px), int'(py), int'(px), int'(py),
                         int'(rand_in(COORD_MAX)), int'(rand_in(COORD_MAX)),
                         int'(rand_in(COORD_MAX)), int'(rand_in(COORD_MAX)));
      end
      send_pair(pair, pick_gap());
    end
  endtask

  // Main sequence.
  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_cases();
    test_drain_pause();
    test_back_to_back();
    test_random_mix();

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d segment pairs, checked %0d results:", n_sent, n_checked);
    $display("  %0d crossings with a point, %0d collinear hits, %0d misses.",
             n_points, n_collinear, n_misses);
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
